>>> sv/timer_group_with_watchdog_assert.svh
// assertion macros shared by the timer group rtl
`ifndef TIMER_GROUP_WITH_WATCHDOG_ASSERT_SVH
`define TIMER_GROUP_WITH_WATCHDOG_ASSERT_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define TGW_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TGW_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/tgw_pkg.sv
// shared types and constants for the timer group with watchdog
`default_nettype none

package tgw_pkg;

    localparam int COUNTER_WIDTH  = 54;
    localparam int DIVIDER_WIDTH  = 16;
    localparam int DATA_WIDTH     = 32;
    localparam int HI_WIDTH       = COUNTER_WIDTH - DATA_WIDTH;
    localparam int PRESCALE_WIDTH = 16;

    // timer cfg layout
    localparam int TC_EN_BIT    = 31;
    localparam int TC_UP_BIT    = 30;
    localparam int TC_AR_BIT    = 29;
    localparam int TC_DIV_LSB   = 13;
    localparam int TC_ALARM_BIT = 10;

    // watchdog cfg layout
    localparam int WD_EN_BIT      = 31;
    localparam int WD_ACT_LSB     = 29;
    localparam int WD_UPDATE_BIT  = 22;
    localparam int WD_PRE_LSB     = 16;

    // raw / clear layout
    localparam int RAW_TIMER_BIT = 0;
    localparam int RAW_WDT_BIT   = 1;

    localparam logic [DATA_WIDTH-1:0] UNLOCK_KEY_RESET = 32'h50D8_3AA1;

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_READ  = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        REG_TCFG      = 4'd0,
        REG_LO        = 4'd1,
        REG_HI        = 4'd2,
        REG_UPDATE    = 4'd3,
        REG_ALARM_LO  = 4'd4,
        REG_ALARM_HI  = 4'd5,
        REG_LOAD_LO   = 4'd6,
        REG_LOAD_HI   = 4'd7,
        REG_RAW       = 4'd8,
        REG_CLEAR     = 4'd9,
        REG_WCFG0     = 4'd10,
        REG_WCFG1     = 4'd11,
        REG_WCFG2     = 4'd12,
        REG_FEED      = 4'd13,
        REG_PROTECT   = 4'd14
    } t_reg_sel;

    typedef enum logic [1:0] {
        WD_ACT_OFF = 2'd0,
        WD_ACT_IRQ = 2'd1,
        WD_ACT_CPU = 2'd2,
        WD_ACT_SYS = 2'd3
    } t_wd_act;

    // one request as seen by the timer and watchdog
    typedef struct packed {
        logic                  fire;
        t_kind                 kind;
        t_reg_sel              sel;
        logic [DATA_WIDTH-1:0] data;
    } t_req;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] rdata;
        logic                  pend_next;
    } t_tmr_rsp;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] rdata;
        logic                  pend_next;
        logic                  cpu_rst;
        logic                  sys_rst;
    } t_wdt_rsp;

endpackage

`default_nettype wire

>>> sv/tgw_timer.sv
// general-purpose up/down counter with divider, alarm and auto-reload
`default_nettype none

module tgw_timer import tgw_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_req     i_req,
    output t_tmr_rsp o_rsp
);

    logic [COUNTER_WIDTH-1:0] r_count, n_count;
    logic [COUNTER_WIDTH-1:0] r_latched, n_latched;
    logic [COUNTER_WIDTH-1:0] r_alarm, n_alarm;
    logic [COUNTER_WIDTH-1:0] r_reload, n_reload;
    logic                     r_en, n_en;
    logic                     r_up, n_up;
    logic                     r_ar, n_ar;
    logic                     r_alarm_en, n_alarm_en;
    logic [DIVIDER_WIDTH-1:0] r_div, n_div;
    logic [DIVIDER_WIDTH-1:0] r_div_cnt, n_div_cnt;
    logic                     r_pend, n_pend;

    logic [DIVIDER_WIDTH:0]   w_div_eff;
    logic [DIVIDER_WIDTH:0]   w_dc;
    logic [COUNTER_WIDTH-1:0] w_step;
    logic                     w_hit;
    logic [DATA_WIDTH-1:0]    w_rdata;

    always_comb begin
        n_count    = r_count;
        n_latched  = r_latched;
        n_alarm    = r_alarm;
        n_reload   = r_reload;
        n_en       = r_en;
        n_up       = r_up;
        n_ar       = r_ar;
        n_alarm_en = r_alarm_en;
        n_div      = r_div;
        n_div_cnt  = r_div_cnt;
        n_pend     = r_pend;
        w_hit      = 1'b0;
        // divider field of zero stands for the full range
        w_div_eff  = {(r_div == '0), r_div};
        w_dc       = {1'b0, r_div_cnt} + (DIVIDER_WIDTH + 1)'(1);
        w_step     = r_up ? (r_count + COUNTER_WIDTH'(1)) : (r_count - COUNTER_WIDTH'(1));
        if (i_req.fire) begin
            case (i_req.kind)
                KIND_TICK: begin
                    if (r_en) begin
                        if (w_dc >= w_div_eff) begin
                            n_div_cnt = '0;
                            n_count   = w_step;
                        end else begin
                            n_div_cnt = w_dc[DIVIDER_WIDTH-1:0];
                        end
                        // compare after this tick's step
                        if (r_alarm_en) begin
                            w_hit = r_up ? (n_count >= r_alarm) : (n_count <= r_alarm);
                            if (w_hit) begin
                                n_pend     = 1'b1;
                                n_alarm_en = 1'b0;
                                if (r_ar) begin
                                    n_count = r_reload;
                                end
                            end
                        end
                    end
                end
                KIND_WRITE: begin
                    case (i_req.sel)
                        REG_TCFG: begin
                            n_en       = i_req.data[TC_EN_BIT];
                            n_up       = i_req.data[TC_UP_BIT];
                            n_ar       = i_req.data[TC_AR_BIT];
                            n_alarm_en = i_req.data[TC_ALARM_BIT];
                            n_div      = i_req.data[TC_DIV_LSB +: DIVIDER_WIDTH];
                        end
                        REG_UPDATE:   n_latched = r_count;
                        REG_ALARM_LO: n_alarm   = {r_alarm[COUNTER_WIDTH-1:DATA_WIDTH],
                                                   i_req.data};
                        REG_ALARM_HI: n_alarm   = {i_req.data[HI_WIDTH-1:0],
                                                   r_alarm[DATA_WIDTH-1:0]};
                        REG_LOAD_LO:  n_reload  = {r_reload[COUNTER_WIDTH-1:DATA_WIDTH],
                                                   i_req.data};
                        REG_LOAD_HI:  n_reload  = {i_req.data[HI_WIDTH-1:0],
                                                   r_reload[DATA_WIDTH-1:0]};
                        REG_CLEAR: begin
                            if (i_req.data[RAW_TIMER_BIT]) begin
                                n_pend = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        w_rdata = '0;
        case (i_req.sel)
            REG_TCFG: begin
                w_rdata[TC_EN_BIT]                    = r_en;
                w_rdata[TC_UP_BIT]                    = r_up;
                w_rdata[TC_AR_BIT]                    = r_ar;
                w_rdata[TC_ALARM_BIT]                 = r_alarm_en;
                w_rdata[TC_DIV_LSB +: DIVIDER_WIDTH]  = r_div;
            end
            REG_LO:       w_rdata = r_latched[DATA_WIDTH-1:0];
            REG_HI:       w_rdata = DATA_WIDTH'(r_latched[COUNTER_WIDTH-1:DATA_WIDTH]);
            REG_ALARM_LO: w_rdata = r_alarm[DATA_WIDTH-1:0];
            REG_ALARM_HI: w_rdata = DATA_WIDTH'(r_alarm[COUNTER_WIDTH-1:DATA_WIDTH]);
            REG_LOAD_LO:  w_rdata = r_reload[DATA_WIDTH-1:0];
            REG_LOAD_HI:  w_rdata = DATA_WIDTH'(r_reload[COUNTER_WIDTH-1:DATA_WIDTH]);
            REG_RAW:      w_rdata[RAW_TIMER_BIT] = r_pend;
            default: ;
        endcase
    end

    assign o_rsp.rdata     = w_rdata;
    assign o_rsp.pend_next = n_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_latched  <= '0;
            r_alarm    <= '0;
            r_reload   <= '0;
            r_en       <= 1'b0;
            r_up       <= 1'b1;
            r_ar       <= 1'b0;
            r_alarm_en <= 1'b0;
            r_div      <= DIVIDER_WIDTH'(1);
            r_div_cnt  <= '0;
            r_pend     <= 1'b0;
        end else begin
            r_count    <= n_count;
            r_latched  <= n_latched;
            r_alarm    <= n_alarm;
            r_reload   <= n_reload;
            r_en       <= n_en;
            r_up       <= n_up;
            r_ar       <= n_ar;
            r_alarm_en <= n_alarm_en;
            r_div      <= n_div;
            r_div_cnt  <= n_div_cnt;
            r_pend     <= n_pend;
        end
    end

endmodule

`default_nettype wire

>>> sv/tgw_wdt.sv
// one-stage watchdog with prescaler, write protection and shadow settings
`default_nettype none

module tgw_wdt import tgw_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_req                  i_req,
    input  logic [DATA_WIDTH-1:0] i_unlock_key,
    output t_wdt_rsp              o_rsp
);

    // active settings
    logic                      r_en, n_en;
    t_wd_act                   r_act, n_act;
    logic [PRESCALE_WIDTH-1:0] r_pre, n_pre;
    logic [DATA_WIDTH-1:0]     r_timeout, n_timeout;
    // shadow settings, copied over on an update write
    logic                      r_sh_en, n_sh_en;
    t_wd_act                   r_sh_act, n_sh_act;
    logic [PRESCALE_WIDTH-1:0] r_sh_pre, n_sh_pre;
    logic [DATA_WIDTH-1:0]     r_sh_to, n_sh_to;
    // counts and status
    logic [DATA_WIDTH-1:0]     r_wc, n_wc;
    logic [PRESCALE_WIDTH-1:0] r_pc, n_pc;
    logic                      r_unlocked, n_unlocked;
    logic                      r_pend, n_pend;

    logic [PRESCALE_WIDTH:0]   w_pre_eff;
    logic [PRESCALE_WIDTH:0]   w_pc;
    logic [DATA_WIDTH:0]       w_wc;
    logic                      w_cpu;
    logic                      w_sys;
    logic [DATA_WIDTH-1:0]     w_rdata;

    always_comb begin
        n_en       = r_en;
        n_act      = r_act;
        n_pre      = r_pre;
        n_timeout  = r_timeout;
        n_sh_en    = r_sh_en;
        n_sh_act   = r_sh_act;
        n_sh_pre   = r_sh_pre;
        n_sh_to    = r_sh_to;
        n_wc       = r_wc;
        n_pc       = r_pc;
        n_unlocked = r_unlocked;
        n_pend     = r_pend;
        w_cpu      = 1'b0;
        w_sys      = 1'b0;
        w_pre_eff  = {(r_pre == '0), r_pre};
        w_pc       = {1'b0, r_pc} + (PRESCALE_WIDTH + 1)'(1);
        w_wc       = {1'b0, r_wc} + (DATA_WIDTH + 1)'(1);
        if (i_req.fire) begin
            case (i_req.kind)
                KIND_TICK: begin
                    if (r_en) begin
                        if (w_pc < w_pre_eff) begin
                            n_pc = w_pc[PRESCALE_WIDTH-1:0];
                        end else begin
                            n_pc = '0;
                            if (w_wc >= {1'b0, r_timeout}) begin
                                n_wc = '0;
                                case (r_act)
                                    WD_ACT_IRQ: n_pend = 1'b1;
                                    WD_ACT_CPU: w_cpu  = 1'b1;
                                    WD_ACT_SYS: w_sys  = 1'b1;
                                    default: ;
                                endcase
                            end else begin
                                n_wc = w_wc[DATA_WIDTH-1:0];
                            end
                        end
                    end
                end
                KIND_WRITE: begin
                    case (i_req.sel)
                        REG_PROTECT: n_unlocked = (i_req.data == i_unlock_key);
                        REG_CLEAR: begin
                            if (i_req.data[RAW_WDT_BIT]) begin
                                n_pend = 1'b0;
                            end
                        end
                        REG_WCFG0: begin
                            if (r_unlocked) begin
                                n_sh_en  = i_req.data[WD_EN_BIT];
                                n_sh_act = t_wd_act'(i_req.data[WD_ACT_LSB +: 2]);
                                if (i_req.data[WD_UPDATE_BIT]) begin
                                    n_en      = i_req.data[WD_EN_BIT];
                                    n_act     = t_wd_act'(i_req.data[WD_ACT_LSB +: 2]);
                                    n_pre     = r_sh_pre;
                                    n_timeout = r_sh_to;
                                end
                            end
                        end
                        REG_WCFG1: begin
                            if (r_unlocked) begin
                                n_sh_pre = i_req.data[WD_PRE_LSB +: PRESCALE_WIDTH];
                            end
                        end
                        REG_WCFG2: begin
                            if (r_unlocked) begin
                                n_sh_to = i_req.data;
                            end
                        end
                        REG_FEED: begin
                            if (r_unlocked) begin
                                n_wc = '0;
                                n_pc = '0;
                            end
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        w_rdata = '0;
        case (i_req.sel)
            REG_WCFG0: begin
                w_rdata[WD_EN_BIT]         = r_sh_en;
                w_rdata[WD_ACT_LSB +: 2]   = r_sh_act;
            end
            REG_WCFG1:   w_rdata[WD_PRE_LSB +: PRESCALE_WIDTH] = r_sh_pre;
            REG_WCFG2:   w_rdata = r_sh_to;
            REG_PROTECT: w_rdata[0] = r_unlocked;
            REG_RAW:     w_rdata[RAW_WDT_BIT] = r_pend;
            default: ;
        endcase
    end

    assign o_rsp.rdata     = w_rdata;
    assign o_rsp.pend_next = n_pend;
    assign o_rsp.cpu_rst   = w_cpu;
    assign o_rsp.sys_rst   = w_sys;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en       <= 1'b0;
            r_act      <= WD_ACT_OFF;
            r_pre      <= PRESCALE_WIDTH'(1);
            r_timeout  <= '1;
            r_sh_en    <= 1'b0;
            r_sh_act   <= WD_ACT_OFF;
            r_sh_pre   <= PRESCALE_WIDTH'(1);
            r_sh_to    <= '1;
            r_wc       <= '0;
            r_pc       <= '0;
            r_unlocked <= 1'b0;
            r_pend     <= 1'b0;
        end else begin
            r_en       <= n_en;
            r_act      <= n_act;
            r_pre      <= n_pre;
            r_timeout  <= n_timeout;
            r_sh_en    <= n_sh_en;
            r_sh_act   <= n_sh_act;
            r_sh_pre   <= n_sh_pre;
            r_sh_to    <= n_sh_to;
            r_wc       <= n_wc;
            r_pc       <= n_pc;
            r_unlocked <= n_unlocked;
            r_pend     <= n_pend;
        end
    end

endmodule

`default_nettype wire

>>> sv/timer_group_with_watchdog.sv
// Timer group with watchdog: top level, request and result registers.
// Requests arrive on i_valid / o_stall: kind (tick, register write or
// register read), register select and write data. Each request gives one
// result on o_valid / i_stall: read data (zero unless a read), the timer
// alarm and watchdog interrupt pending bits as they stand after the request,
// and one-request pulses for a watchdog cpu or system reset.
// A request that is taken is held in the request register, worked through the
// timer and watchdog logic once it can move on, and its result is shown
// from the result register. Throughput is one request per cycle while the
// receiver does not stall; the limit is the combinational update of the
// counter (54-bit step followed by the alarm compare).
// When the receiver stalls, the result register holds its contents and the
// request register keeps the next request; o_stall rises only once both
// are full. The unlock key is written on i_cfg_valid / o_cfg_ready, ready
// always high, and should only change while no request is in flight.
// Synchronous active-low reset returns all timer and watchdog state to its
// defaults and empties both registers; no clearing pass is needed.
`default_nettype none

`include "timer_group_with_watchdog_assert.svh"

module timer_group_with_watchdog import tgw_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [1:0]            i_kind,
    input  logic [3:0]            i_reg_select,
    input  logic [DATA_WIDTH-1:0] i_write_data,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [DATA_WIDTH-1:0] o_read_data,
    output logic                  o_timer_alarm_pending,
    output logic                  o_watchdog_irq_pending,
    output logic                  o_cpu_reset,
    output logic                  o_system_reset,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [DATA_WIDTH-1:0] i_cfg_data
);

    logic                  r_in_vld;
    t_kind                 r_in_kind;
    logic [3:0]            r_in_sel;
    logic [DATA_WIDTH-1:0] r_in_data;

    logic                  r_out_vld;
    logic [DATA_WIDTH-1:0] r_out_rdata;
    logic                  r_out_tpend;
    logic                  r_out_wpend;
    logic                  r_out_cpu;
    logic                  r_out_sys;

    logic [DATA_WIDTH-1:0] r_unlock_key;

    logic                  w_adv;
    logic [DATA_WIDTH-1:0] w_rdata;
    t_req                  w_req;
    t_tmr_rsp              w_tmr_rsp;
    t_wdt_rsp              w_wdt_rsp;

    // request moves on when the result register is free or being emptied
    assign w_adv   = r_in_vld && (!r_out_vld || !i_stall);
    assign o_stall = r_in_vld && !w_adv;

    assign w_req.fire = w_adv;
    assign w_req.kind = r_in_kind;
    assign w_req.sel  = t_reg_sel'(r_in_sel);
    assign w_req.data = r_in_data;

    tgw_timer u_timer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_tmr_rsp)
    );

    tgw_wdt u_wdt (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (w_req),
        .i_unlock_key (r_unlock_key),
        .o_rsp        (w_wdt_rsp)
    );

    assign w_rdata = (r_in_kind == KIND_READ) ? (w_tmr_rsp.rdata | w_wdt_rsp.rdata) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_stall) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_kind <= t_kind'(i_kind);
            r_in_sel  <= i_reg_select;
            r_in_data <= i_write_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld   <= 1'b0;
            r_out_tpend <= 1'b0;
            r_out_wpend <= 1'b0;
            r_out_cpu   <= 1'b0;
            r_out_sys   <= 1'b0;
        end else if (w_adv) begin
            r_out_vld   <= 1'b1;
            r_out_tpend <= w_tmr_rsp.pend_next;
            r_out_wpend <= w_wdt_rsp.pend_next;
            r_out_cpu   <= w_wdt_rsp.cpu_rst;
            r_out_sys   <= w_wdt_rsp.sys_rst;
        end else if (!i_stall) begin
            r_out_vld   <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_rdata <= w_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unlock_key <= UNLOCK_KEY_RESET;
        end else if (i_cfg_valid) begin
            r_unlock_key <= i_cfg_data;
        end
    end

    assign o_cfg_ready            = 1'b1;
    assign o_valid                = r_out_vld;
    assign o_read_data            = r_out_rdata;
    assign o_timer_alarm_pending  = r_out_tpend;
    assign o_watchdog_irq_pending = r_out_wpend;
    assign o_cpu_reset            = r_out_cpu;
    assign o_system_reset         = r_out_sys;

    `TGW_ASSERT_IMP(a_stall_needs_request, o_stall, r_in_vld, "stall with empty request register")
    `TGW_ASSERT_NXT(a_rdata_zero_unless_read, w_adv && (r_in_kind != KIND_READ), o_read_data == '0, "read data not zero")
    `TGW_ASSERT_IMP(a_single_reset_kind, o_valid, !(o_cpu_reset && o_system_reset), "both reset kinds at once")
    `TGW_ASSERT_IMP(a_alarm_from_tick, $rose(o_timer_alarm_pending), $past(w_adv && (r_in_kind == KIND_TICK)), "alarm pending set without a tick")

endmodule

`default_nettype wire
